// ===== src/itpa_pkg.sv =====
// shared types and constants of the padded ascii integer formatter
`timescale 1ns / 1ps

package itpa_pkg;

  localparam int unsigned VAL_W      = 64;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned FWIDTH_W   = 6;
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned NIB_W      = 4;
  localparam int unsigned DEC_DIGITS = 20;
  localparam int unsigned BCD_W      = DEC_DIGITS * NIB_W;
  localparam int unsigned SR_W       = BCD_W + VAL_W;
  localparam int unsigned DCNT_W     = $clog2(DEC_DIGITS + 1);
  localparam int unsigned CCNT_W     = $clog2(VAL_W);

  localparam logic [KIND_W-1:0] KIND_UDEC = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SDEC = 3'd1;
  localparam logic [KIND_W-1:0] KIND_HEXL = 3'd2;
  localparam logic [KIND_W-1:0] KIND_HEXU = 3'd3;
  localparam logic [KIND_W-1:0] KIND_CHAR = 3'd4;

  localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
  localparam logic [CHAR_W-1:0] CH_MINUS = 8'h2d;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] CH_UA    = 8'h41;
  localparam logic [CHAR_W-1:0] CH_LA    = 8'h61;

  typedef enum logic [1:0] {
    SEL_PAD  = 2'd0,
    SEL_SIGN = 2'd1,
    SEL_DIG  = 2'd2
  } sel_t;

  typedef struct packed {
    logic load;
    logic conv_step;
    logic norm_step;
    logic pad_load;
    logic out_load;
    sel_t sel;
    logic out_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic kind_ok;
    logic need_conv;
    logic conv_last;
    logic norm_done;
    logic pad_zero;
    logic pad_one;
    logic dig_one;
    logic neg;
    logic left;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== src/integer_to_padded_ascii_top.sv =====
// Formats one integer field request into a stream of padded ascii characters.
// Input channel: in_valid/in_stall with in_kind, in_is_wide, in_value, in_width,
//   in_zero_lead and in_left_align; one transaction is one field request.
// Output channel: out_valid/out_stall with out_char and out_last; one transaction
//   per character, out_last set on the final character of the field.
// Decimal kinds run a double dabble conversion of the magnitude, one bit per cycle;
//   decimal and hex kinds then drop the leading zero digits.
// Characters leave at one per cycle through the output register unless the output
//   stalls; a right-aligned field closes its front pad run in a step that sends no
//   character, and the sign step is taken whether or not a minus is sent.
// The input stays stalled after a defined request until its last character is
//   loaded into the output register.
// Requests with an undefined kind are taken and dropped without output.
// A stall on the output holds the current character and pauses the sequencer in its
//   output steps.
// Synchronous active-low reset returns the sequencer to idle and empties the
//   output register.
`timescale 1ns / 1ps

module integer_to_padded_ascii_top
  import itpa_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic                in_is_wide,
  input  logic [VAL_W-1:0]    in_value,
  input  logic [FWIDTH_W-1:0] in_width,
  input  logic                in_zero_lead,
  input  logic                in_left_align,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_char,
  output logic                out_last
);

  ctl_cmd_t cmd;
  ctl_sts_t sts;

  itpa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  itpa_datapath #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_kind       (in_kind),
    .in_is_wide    (in_is_wide),
    .in_value      (in_value),
    .in_width      (in_width),
    .in_zero_lead  (in_zero_lead),
    .in_left_align (in_left_align),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_char      (out_char),
    .out_last      (out_last),
    .cmd           (cmd),
    .sts           (sts)
  );

endmodule

// ===== src/itpa_ctrl.sv =====
// controller state machine of the padded ascii integer formatter
`timescale 1ns / 1ps

module itpa_ctrl
  import itpa_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  ctl_sts_t sts,
  output ctl_cmd_t cmd
);

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_CONV = 7'b0000010,
    S_NORM = 7'b0000100,
    S_PADF = 7'b0001000,
    S_SIGN = 7'b0010000,
    S_DIG  = 7'b0100000,
    S_PADB = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    cmd.sel   = SEL_PAD;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          if (sts.kind_ok) begin
            state_nxt = sts.need_conv ? S_CONV : S_NORM;
          end
        end
      end
      S_CONV: begin
        cmd.conv_step = 1'b1;
        if (sts.conv_last) begin
          state_nxt = S_NORM;
        end
      end
      S_NORM: begin
        if (sts.norm_done) begin
          cmd.pad_load = 1'b1;
          state_nxt    = sts.left ? S_SIGN : S_PADF;
        end else begin
          cmd.norm_step = 1'b1;
        end
      end
      S_PADF: begin
        if (sts.pad_zero) begin
          state_nxt = S_SIGN;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_PAD;
        end
      end
      S_SIGN: begin
        if (!sts.neg) begin
          state_nxt = S_DIG;
        end else if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_SIGN;
          state_nxt    = S_DIG;
        end
      end
      S_DIG: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_DIG;
          cmd.out_last = sts.dig_one && (!sts.left || sts.pad_zero);
          if (sts.dig_one) begin
            state_nxt = (sts.left && !sts.pad_zero) ? S_PADB : S_IDLE;
          end
        end
      end
      S_PADB: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.sel      = SEL_PAD;
          cmd.out_last = sts.pad_one;
          if (sts.pad_one) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// ===== src/itpa_datapath.sv =====
// datapath: operand load, double dabble, digit normalisation, padding and output register
`timescale 1ns / 1ps

module itpa_datapath
  import itpa_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [KIND_W-1:0]   in_kind,
  input  logic                in_is_wide,
  input  logic [VAL_W-1:0]    in_value,
  input  logic [FWIDTH_W-1:0] in_width,
  input  logic                in_zero_lead,
  input  logic                in_left_align,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [CHAR_W-1:0]   out_char,
  output logic                out_last,
  input  ctl_cmd_t            cmd,
  output ctl_sts_t            sts
);

  localparam logic [FWIDTH_W-1:0] WCAP = FWIDTH_W'(MAX_WIDTH);

  logic [SR_W-1:0]     sr_r;
  logic [CCNT_W-1:0]   conv_cnt_r;
  logic [DCNT_W-1:0]   dig_cnt_r;
  logic [FWIDTH_W-1:0] pad_r;
  logic [FWIDTH_W-1:0] width_r;
  logic [CHAR_W-1:0]   char_r;
  logic                neg_r, left_r, zpad_r, upper_r, is_char_r;
  logic                out_valid_r, out_last_r;
  logic [CHAR_W-1:0]   out_char_r;

  logic [VAL_W-1:0]    ext;
  logic [VAL_W-1:0]    mag;
  logic                neg;
  logic                is_dec;
  logic [BCD_W-1:0]    bcd_adj;
  logic [NIB_W-1:0]    top_nib;
  logic [DCNT_W-1:0]   tlen;
  logic [FWIDTH_W-1:0] tlen_x;
  logic [CHAR_W-1:0]   dig_char;
  logic [CHAR_W-1:0]   sel_char;

  assign is_dec = (in_kind == KIND_UDEC) || (in_kind == KIND_SDEC);

  always_comb begin
    ext = in_is_wide ? in_value : {{(VAL_W/2){in_value[VAL_W/2-1]}}, in_value[VAL_W/2-1:0]};
    neg = (in_kind == KIND_SDEC) && (in_is_wide ? in_value[VAL_W-1] : in_value[VAL_W/2-1]);
    if (neg) begin
      mag = '0 - ext;
    end else if (in_is_wide) begin
      mag = in_value;
    end else begin
      mag = {{(VAL_W/2){1'b0}}, in_value[VAL_W/2-1:0]};
    end
  end

  always_comb begin
    for (int i = 0; i < DEC_DIGITS; i++) begin
      bcd_adj[i*NIB_W +: NIB_W] = (sr_r[VAL_W + i*NIB_W +: NIB_W] >= 4'd5)
                                  ? sr_r[VAL_W + i*NIB_W +: NIB_W] + 4'd3
                                  : sr_r[VAL_W + i*NIB_W +: NIB_W];
    end
  end

  assign top_nib = sr_r[SR_W-1 -: NIB_W];
  assign tlen    = is_char_r ? DCNT_W'(1) : dig_cnt_r + DCNT_W'(neg_r);
  assign tlen_x  = FWIDTH_W'(tlen);

  always_comb begin
    if (top_nib < 4'd10) begin
      dig_char = CH_ZERO + {4'b0, top_nib};
    end else begin
      dig_char = (upper_r ? CH_UA : CH_LA) + {4'b0, top_nib} - 8'd10;
    end
    case (cmd.sel)
      SEL_PAD:  sel_char = zpad_r ? CH_ZERO : CH_SPACE;
      SEL_SIGN: sel_char = CH_MINUS;
      SEL_DIG:  sel_char = is_char_r ? char_r : dig_char;
      default:  sel_char = CH_SPACE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      width_r    <= (in_width > WCAP) ? WCAP : in_width;
      neg_r      <= neg;
      left_r     <= in_left_align;
      is_char_r  <= (in_kind == KIND_CHAR);
      zpad_r     <= in_zero_lead && !in_left_align && (in_kind != KIND_CHAR);
      upper_r    <= (in_kind == KIND_HEXU);
      char_r     <= in_value[CHAR_W-1:0];
      conv_cnt_r <= '0;
      dig_cnt_r  <= (in_kind == KIND_CHAR) ? DCNT_W'(1) : DCNT_W'(DEC_DIGITS);
      if (is_dec) begin
        sr_r <= {{BCD_W{1'b0}}, mag};
      end else begin
        sr_r <= {{(BCD_W-VAL_W){1'b0}}, mag, {VAL_W{1'b0}}};
      end
    end else if (cmd.conv_step) begin
      sr_r       <= {bcd_adj, sr_r[VAL_W-1:0]} << 1;
      conv_cnt_r <= conv_cnt_r + CCNT_W'(1);
    end else if (cmd.norm_step || (cmd.out_load && cmd.sel == SEL_DIG)) begin
      sr_r      <= sr_r << NIB_W;
      dig_cnt_r <= dig_cnt_r - DCNT_W'(1);
    end
    if (cmd.pad_load) begin
      pad_r <= (width_r > tlen_x) ? width_r - tlen_x : '0;
    end else if (cmd.out_load && cmd.sel == SEL_PAD) begin
      pad_r <= pad_r - FWIDTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_char_r <= sel_char;
      out_last_r <= cmd.out_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_char  = out_char_r;
  assign out_last  = out_last_r;

  assign sts.kind_ok   = (in_kind <= KIND_CHAR);
  assign sts.need_conv = is_dec;
  assign sts.conv_last = (conv_cnt_r == CCNT_W'(VAL_W - 1));
  assign sts.norm_done = is_char_r || (dig_cnt_r == DCNT_W'(1)) || (top_nib != '0);
  assign sts.pad_zero  = (pad_r == '0);
  assign sts.pad_one   = (pad_r == FWIDTH_W'(1));
  assign sts.dig_one   = (dig_cnt_r == DCNT_W'(1));
  assign sts.neg       = neg_r;
  assign sts.left      = left_r;
  assign sts.out_free  = !out_valid_r || !out_stall;

endmodule

// ===== src/itpa_checker.sv =====
// port-level checker of the padded ascii integer formatter and its bind
`timescale 1ns / 1ps

module itpa_checker
  import itpa_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic [KIND_W-1:0]   in_kind,
  input logic                out_valid,
  input logic                out_stall,
  input logic [CHAR_W-1:0]   out_char,
  input logic                out_last
);

  // stalled output transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_char) && $stable(out_last))
    else $error("stalled output transaction changed");

  // a defined request keeps the input busy while it is formatted
  a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind <= KIND_CHAR) |=> in_stall)
    else $error("input not stalled after a defined request");

  // an undefined request is dropped at once
  a_drop_undef: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_kind > KIND_CHAR) |=> !in_stall)
    else $error("undefined request not dropped");

  // reset empties the output register
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind integer_to_padded_ascii_top itpa_checker u_itpa_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_kind   (in_kind),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_char  (out_char),
  .out_last  (out_last)
);

// ===== dv/tb_top.sv =====
// self-checking testbench for the padded ascii integer field formatter
`timescale 1ns / 1ps

module tb_top
  import itpa_pkg::*;
();

  localparam int unsigned FIELD_MAX    = 63;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned HOLD_CYCLES  = 250;

  // codes that the block takes and drops without output
  localparam logic [KIND_W-1:0] KIND_RSVD_A = 3'd5;
  localparam logic [KIND_W-1:0] KIND_RSVD_B = 3'd6;
  localparam logic [KIND_W-1:0] KIND_RSVD_C = 3'd7;

  typedef struct {
    logic [KIND_W-1:0]   kind;
    logic                is_wide;
    logic [VAL_W-1:0]    value;
    logic [FWIDTH_W-1:0] width;
    logic                zero_lead;
    logic                left_align;
  } field_req_t;

  typedef struct {
    logic [CHAR_W-1:0] ch;
    logic              last;
  } field_char_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_stall;
  logic [KIND_W-1:0]   in_kind;
  logic                in_is_wide;
  logic [VAL_W-1:0]    in_value;
  logic [FWIDTH_W-1:0] in_width;
  logic                in_zero_lead;
  logic                in_left_align;
  logic                out_valid;
  logic                out_stall;
  logic [CHAR_W-1:0]   out_char;
  logic                out_last;

  field_char_t pending_chars[$];
  field_char_t head_char;
  int unsigned err_count  = 0;
  int unsigned hold_ask   = 0;
  int unsigned quiet_cycles;
  bit          tx_idle_on = 1'b1;
  bit          rx_idle_on = 1'b1;

  integer_to_padded_ascii_top #(
    .MAX_WIDTH(FIELD_MAX)
  ) i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_kind      (in_kind),
    .in_is_wide   (in_is_wide),
    .in_value     (in_value),
    .in_width     (in_width),
    .in_zero_lead (in_zero_lead),
    .in_left_align(in_left_align),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_char     (out_char),
    .out_last     (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic field_req_t mk_field(logic [KIND_W-1:0] kind, logic is_wide,
                                          logic [VAL_W-1:0] value,
                                          logic [FWIDTH_W-1:0] width,
                                          logic zero_lead, logic left_align);
    field_req_t r;
    r.kind       = kind;
    r.is_wide    = is_wide;
    r.value      = value;
    r.width      = width;
    r.zero_lead  = zero_lead;
    r.left_align = left_align;
    return r;
  endfunction

  // renders one request into the characters the block must emit
  function automatic void format_field(field_req_t req);
    logic [CHAR_W-1:0] text[$];
    logic [VAL_W-1:0]  mag;
    logic [NIB_W-1:0]  dig;
    logic [CHAR_W-1:0] pad_ch;
    logic              neg;
    logic              zlead;
    int unsigned       radix;
    int unsigned       fw;
    int unsigned       pad;
    field_char_t       c;
    field_char_t       seq[$];
    if (req.kind > KIND_CHAR) return;
    fw = req.width;
    if (fw > FIELD_MAX) fw = FIELD_MAX;
    zlead = req.zero_lead && !req.left_align;
    if (req.kind == KIND_CHAR) begin
      text.push_back(req.value[CHAR_W-1:0]);
      zlead = 1'b0;
    end else begin
      mag = req.is_wide ? req.value : {32'b0, req.value[31:0]};
      neg = 1'b0;
      if (req.kind == KIND_SDEC) begin
        neg = req.is_wide ? req.value[63] : req.value[31];
        if (neg) begin
          if (!req.is_wide) mag[63:32] = '1;
          mag = -mag;
        end
      end
      radix = (req.kind == KIND_HEXL || req.kind == KIND_HEXU) ? 16 : 10;
      do begin
        dig = NIB_W'(mag % radix);
        mag = mag / radix;
        if (dig < 10) text.push_front(CH_ZERO + CHAR_W'(dig));
        else text.push_front((req.kind == KIND_HEXU ? CH_UA : CH_LA) + CHAR_W'(dig)
                             - CHAR_W'(10));
      end while (mag != 0);
      if (neg) text.push_front(CH_MINUS);
    end
    pad    = (fw > text.size()) ? fw - text.size() : 0;
    pad_ch = zlead ? CH_ZERO : CH_SPACE;
    c.last = 1'b0;
    if (!req.left_align) begin
      c.ch = pad_ch;
      repeat (pad) seq.push_back(c);
    end
    foreach (text[i]) begin
      c.ch = text[i];
      seq.push_back(c);
    end
    if (req.left_align) begin
      c.ch = CH_SPACE;
      repeat (pad) seq.push_back(c);
    end
    seq[seq.size() - 1].last = 1'b1;
    foreach (seq[i]) pending_chars.push_back(seq[i]);
  endfunction

  function automatic field_req_t random_field();
    field_req_t  r;
    logic [VAL_W-1:0] v;
    v = {$urandom, $urandom};
    if ($urandom_range(0, 15) == 0) r.kind = KIND_W'($urandom_range(KIND_RSVD_A, KIND_RSVD_C));
    else r.kind = KIND_W'($urandom_range(KIND_UDEC, KIND_CHAR));
    r.is_wide = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: r.value = v;
      1: r.value = VAL_W'($urandom_range(0, 99999));
      2: r.value = -VAL_W'($urandom_range(1, 99999));
      default: r.value = (64'd1 << $urandom_range(0, 63)) - VAL_W'($urandom_range(0, 1));
    endcase
    r.width      = $urandom_range(0, 1) ? FWIDTH_W'($urandom_range(0, 12))
                                        : FWIDTH_W'($urandom_range(0, 63));
    r.zero_lead  = 1'($urandom_range(0, 1));
    r.left_align = 1'($urandom_range(0, 1));
    return r;
  endfunction

  // call at a falling edge; returns at the falling edge after the transaction
  task automatic send_field(field_req_t req);
    int unsigned gap;
    gap = tx_idle_on ? $urandom_range(0, 7) : 0;
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_kind       = req.kind;
    in_is_wide    = req.is_wide;
    in_value      = req.value;
    in_width      = req.width;
    in_zero_lead  = req.zero_lead;
    in_left_align = req.left_align;
    in_valid      = 1'b1;
    do @(posedge clk); while (in_stall);
    format_field(req);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_valid = 1'b0;
    while (pending_chars.size() != 0) @(negedge clk);
  endtask

  task automatic test_directed();
    field_req_t list[$];
    list.push_back(mk_field(KIND_UDEC, 1'b0, 64'd0, 6'd0, 1'b0, 1'b0));
    list.push_back(mk_field(KIND_UDEC, 1'b0, '1, 6'd12, 1'b0, 1'b0));
    list.push_back(mk_field(KIND_UDEC, 1'b1, '1, 6'd24, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_UDEC, 1'b1, 64'h8000_0000_0000_0000, 6'd21, 1'b0, 1'b0));
    list.push_back(mk_field(KIND_UDEC, 1'b0, 64'd42, 6'd63, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_SDEC, 1'b0, 64'h0000_0000_8000_0000, 6'd14, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_SDEC, 1'b1, 64'h8000_0000_0000_0000, 6'd22, 1'b0, 1'b1));
    list.push_back(mk_field(KIND_SDEC, 1'b1, 64'h8000_0000_0000_0000, 6'd25, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_SDEC, 1'b0, 64'h1234_5678_FFFF_FFFF, 6'd4, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_SDEC, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF, 6'd0, 1'b0, 1'b0));
    list.push_back(mk_field(KIND_SDEC, 1'b0, 64'hFFFF_FFFF_7FFF_FFFF, 6'd11, 1'b1, 1'b1));
    list.push_back(mk_field(KIND_HEXL, 1'b0, 64'hFFFF_FFFF_DEAD_BEEF, 6'd10, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_HEXL, 1'b1, 64'h0123_4567_89AB_CDEF, 6'd0, 1'b0, 1'b0));
    list.push_back(mk_field(KIND_HEXU, 1'b1, '1, 6'd63, 1'b0, 1'b1));
    list.push_back(mk_field(KIND_HEXU, 1'b0, 64'd0, 6'd63, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_HEXU, 1'b1, 64'hFEDC_BA98_7654_3210, 6'd17, 1'b0, 1'b0));
    list.push_back(mk_field(KIND_CHAR, 1'b1, 64'hFFFF_FFFF_FFFF_FF41, 6'd5, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_CHAR, 1'b0, 64'd0, 6'd3, 1'b0, 1'b1));
    list.push_back(mk_field(KIND_CHAR, 1'b0, 64'hFF, 6'd0, 1'b0, 1'b0));
    list.push_back(mk_field(KIND_RSVD_A, 1'b1, '1, 6'd63, 1'b1, 1'b0));
    list.push_back(mk_field(KIND_RSVD_B, 1'b0, 64'd5, 6'd8, 1'b0, 1'b1));
    list.push_back(mk_field(KIND_RSVD_C, 1'b0, 64'd0, 6'd0, 1'b0, 1'b0));
    foreach (list[i]) send_field(list[i]);
  endtask

  task automatic test_random_fields();
    repeat (180) send_field(random_field());
  endtask

  // output held off long enough that the block stalls its input
  task automatic test_back_pressure();
    hold_ask   = HOLD_CYCLES;
    tx_idle_on = 1'b0;
    repeat (12) send_field(random_field());
    tx_idle_on = 1'b1;
  endtask

  task automatic test_drain_pause();
    repeat (10) send_field(random_field());
    wait_drained();
    repeat (10) send_field(random_field());
  endtask

  task automatic test_without_idling();
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    repeat (20) send_field(random_field());
    wait_drained();
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
  endtask

  initial begin : receiver
    int unsigned wait_left;
    int unsigned hold_left;
    wait_left = 0;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_ask != 0) begin
        hold_left = hold_ask;
        hold_ask  = 0;
      end
      if (hold_left != 0) begin
        out_stall = 1'b1;
        hold_left--;
      end else if (wait_left != 0) begin
        out_stall = 1'b1;
        wait_left--;
      end else begin
        out_stall = 1'b0;
      end
      @(posedge clk);
      if (out_valid && !out_stall) wait_left = rx_idle_on ? $urandom_range(0, 7) : 0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        $error("out_char: unexpected transaction, actual %h", out_char);
        err_count++;
      end else begin
        head_char = pending_chars.pop_front();
        if (out_char !== head_char.ch) begin
          $error("out_char mismatch: expected %h, actual %h", head_char.ch, out_char);
          err_count++;
        end
        if (out_last !== head_char.last) begin
          $error("out_last mismatch: expected %b, actual %b", head_char.last, out_last);
          err_count++;
        end
      end
    end
  end

  initial begin : watchdog
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst_n && ((in_valid && !in_stall) || (out_valid && !out_stall))) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_kind       = KIND_UDEC;
    in_is_wide    = 1'b0;
    in_value      = '0;
    in_width      = '0;
    in_zero_lead  = 1'b0;
    in_left_align = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);
    test_directed();
    test_random_fields();
    test_back_pressure();
    test_drain_pause();
    test_without_idling();
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && pending_chars.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
